// ----- hdl/itf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types, microcode encodings and the control store of the formatter.
// ----------------------------------------------------------------------------
package itf_pkg;

  // request modes
  localparam logic [2:0] MODE_SDEC  = 3'd0;
  localparam logic [2:0] MODE_UDEC  = 3'd1;
  localparam logic [2:0] MODE_OCT   = 3'd2;
  localparam logic [2:0] MODE_HEXL  = 3'd3;
  localparam logic [2:0] MODE_HEXU  = 3'd4;
  localparam logic [2:0] MODE_PTR   = 3'd5;

  // character constants
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;

  // digit buffer geometry
  localparam int DIG_SLOTS = 22;
  localparam int DIG_BITS  = DIG_SLOTS * 4;
  localparam int BCD_SLOTS = 20;
  localparam int BCD_BITS  = BCD_SLOTS * 4;
  localparam int CNT_W     = 5;

  // emit selects
  localparam logic [2:0] EM_NONE  = 3'd0;
  localparam logic [2:0] EM_MINUS = 3'd1;
  localparam logic [2:0] EM_ZERO  = 3'd2;
  localparam logic [2:0] EM_X     = 3'd3;
  localparam logic [2:0] EM_DIGIT = 3'd4;

  // datapath operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_NEG   = 3'd1;
  localparam logic [2:0] OP_DAB   = 3'd2;
  localparam logic [2:0] OP_DIGLD = 3'd3;
  localparam logic [2:0] OP_SKIPZ = 3'd4;
  localparam logic [2:0] OP_DEC   = 3'd5;

  // jump conditions
  localparam logic [3:0] CD_NEVER   = 4'd0;
  localparam logic [3:0] CD_ALWAYS  = 4'd1;
  localparam logic [3:0] CD_NOREQ   = 4'd2;
  localparam logic [3:0] CD_BADMODE = 4'd3;
  localparam logic [3:0] CD_PTR     = 4'd4;
  localparam logic [3:0] CD_POW2    = 4'd5;
  localparam logic [3:0] CD_NOTNEG  = 4'd6;
  localparam logic [3:0] CD_DABMORE = 4'd7;
  localparam logic [3:0] CD_LEADZ   = 4'd8;
  localparam logic [3:0] CD_CNTNZ   = 4'd9;

  // program steps
  localparam logic [3:0] ST_WAIT  = 4'd0;
  localparam logic [3:0] ST_BAD   = 4'd1;
  localparam logic [3:0] ST_PTRQ  = 4'd2;
  localparam logic [3:0] ST_POWQ  = 4'd3;
  localparam logic [3:0] ST_NEGQ  = 4'd4;
  localparam logic [3:0] ST_MINUS = 4'd5;
  localparam logic [3:0] ST_DAB   = 4'd6;
  localparam logic [3:0] ST_DIGLD = 4'd7;
  localparam logic [3:0] ST_SKIP  = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;
  localparam logic [3:0] ST_PZERO = 4'd10;
  localparam logic [3:0] ST_PX    = 4'd11;

  typedef struct packed {
    logic       take;
    logic [2:0] emit;
    logic [2:0] op;
    logic [3:0] cond;
    logic       fin;
    logic [3:0] target;
  } ctrl_t;

  typedef struct packed {
    logic badmode;
    logic ptr;
    logic pow2;
    logic neg;
    logic dab_more;
    logic leadz;
    logic cnt_nz;
    logic out_busy;
  } flags_t;

  function automatic ctrl_t mk(input logic take, input logic [2:0] emit,
                               input logic [2:0] op, input logic [3:0] cond,
                               input logic fin, input logic [3:0] target);
    ctrl_t w;
    w.take   = take;
    w.emit   = emit;
    w.op     = op;
    w.cond   = cond;
    w.fin    = fin;
    w.target = target;
    return w;
  endfunction

  // control store
  function automatic ctrl_t rom(input logic [3:0] pc);
    ctrl_t w;
    unique case (pc)
      ST_WAIT:  w = mk(1'b1, EM_NONE,  OP_NONE,  CD_NOREQ,   1'b0, ST_WAIT);
      ST_BAD:   w = mk(1'b0, EM_NONE,  OP_NONE,  CD_BADMODE, 1'b0, ST_WAIT);
      ST_PTRQ:  w = mk(1'b0, EM_NONE,  OP_NONE,  CD_PTR,     1'b0, ST_PZERO);
      ST_POWQ:  w = mk(1'b0, EM_NONE,  OP_NONE,  CD_POW2,    1'b0, ST_DIGLD);
      ST_NEGQ:  w = mk(1'b0, EM_NONE,  OP_NONE,  CD_NOTNEG,  1'b0, ST_DAB);
      ST_MINUS: w = mk(1'b0, EM_MINUS, OP_NEG,   CD_NEVER,   1'b0, ST_WAIT);
      ST_DAB:   w = mk(1'b0, EM_NONE,  OP_DAB,   CD_DABMORE, 1'b0, ST_DAB);
      ST_DIGLD: w = mk(1'b0, EM_NONE,  OP_DIGLD, CD_NEVER,   1'b0, ST_WAIT);
      ST_SKIP:  w = mk(1'b0, EM_NONE,  OP_SKIPZ, CD_LEADZ,   1'b0, ST_SKIP);
      ST_EMIT:  w = mk(1'b0, EM_DIGIT, OP_DEC,   CD_CNTNZ,   1'b1, ST_EMIT);
      ST_PZERO: w = mk(1'b0, EM_ZERO,  OP_NONE,  CD_NEVER,   1'b0, ST_WAIT);
      ST_PX:    w = mk(1'b0, EM_X,     OP_DIGLD, CD_ALWAYS,  1'b0, ST_EMIT);
      default:  w = mk(1'b0, EM_NONE,  OP_NONE,  CD_ALWAYS,  1'b0, ST_WAIT);
    endcase
    return w;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      return CH_ZERO + {4'd0, d};
    end
    return base + {4'd0, d} - 8'd10;
  endfunction

  // highest digit slot to look at, per operand width class
  function automatic logic [CNT_W-1:0] dec_top(input logic [1:0] sz);
    unique case (sz)
      2'd0:    return 5'd2;
      2'd1:    return 5'd4;
      2'd2:    return 5'd9;
      default: return 5'd19;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] oct_top(input logic [1:0] sz);
    unique case (sz)
      2'd0:    return 5'd2;
      2'd1:    return 5'd5;
      2'd2:    return 5'd10;
      default: return 5'd21;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] hex_top(input logic [1:0] sz);
    unique case (sz)
      2'd0:    return 5'd1;
      2'd1:    return 5'd3;
      2'd2:    return 5'd7;
      default: return 5'd15;
    endcase
  endfunction

endpackage

// ----- hdl/itf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itf_if
// Valid/ready channels for number requests and character results.
// ----------------------------------------------------------------------------
interface itf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [1:0]  size_code;
  logic [63:0] value;

  modport source (output valid, output mode, output size_code, output value,
                  input ready);
  modport sink   (input valid, input mode, input size_code, input value,
                  output ready);
endinterface

interface itf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- hdl/itf_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itf_seq
// Step counter, control store and jump logic of the formatter.
// ----------------------------------------------------------------------------
module itf_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  itf_pkg::flags_t flags,
  output itf_pkg::ctrl_t ctrl,
  output logic           go,
  output logic           in_ready
);
  import itf_pkg::*;

  logic [3:0] pc_r;
  logic [3:0] pc_nxt;
  logic       jump;

  assign ctrl     = rom(pc_r);
  assign in_ready = ctrl.take;
  // an emitting step waits for the output register to free up
  assign go       = !((ctrl.emit != EM_NONE) && flags.out_busy);

  always_comb begin
    unique case (ctrl.cond)
      CD_NEVER:   jump = 1'b0;
      CD_ALWAYS:  jump = 1'b1;
      CD_NOREQ:   jump = !in_valid;
      CD_BADMODE: jump = flags.badmode;
      CD_PTR:     jump = flags.ptr;
      CD_POW2:    jump = flags.pow2;
      CD_NOTNEG:  jump = !flags.neg;
      CD_DABMORE: jump = flags.dab_more;
      CD_LEADZ:   jump = flags.leadz;
      CD_CNTNZ:   jump = flags.cnt_nz;
      default:    jump = 1'b1;
    endcase
  end

  always_comb begin
    priority if (!go) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = ctrl.target;
    end else if (ctrl.fin) begin
      pc_nxt = ST_WAIT;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- hdl/itf_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itf_dp
// Operand, bcd and digit registers plus the character output register.
// ----------------------------------------------------------------------------
module itf_dp #(
  parameter int VALUE_BITS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  itf_pkg::ctrl_t  ctrl,
  input  logic            go,
  input  logic            accept,
  input  logic [2:0]      in_mode,
  input  logic [1:0]      in_size_code,
  input  logic [63:0]     in_value,
  input  logic            out_ready,
  output itf_pkg::flags_t flags,
  output logic            out_valid,
  output logic [7:0]      out_char_code,
  output logic            out_last
);
  import itf_pkg::*;

  localparam int NIB = (VALUE_BITS + 3) / 4;
  localparam int VP  = NIB * 4;
  localparam int SW  = $clog2(VP);
  localparam int DCW = $clog2(NIB);

  logic [2:0]          mode_r;
  logic [1:0]          size_r;
  logic [VP-1:0]       val_r;
  logic [VP-1:0]       val_nxt;
  logic [BCD_BITS-1:0] bcd_r;
  logic [BCD_BITS-1:0] bcd_nxt;
  logic [DIG_BITS-1:0] dig_r;
  logic [DIG_BITS-1:0] dig_nxt;
  logic [DCW-1:0]      dab_cnt_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_top;
  logic                out_valid_r;
  logic [7:0]          out_char_r;
  logic                out_last_r;

  logic [6:0]          w_eff;
  logic [VP-1:0]       mask_cur;
  logic [VP-1:0]       in_val_vp;
  logic [SW-1:0]       sign_idx;
  logic [DIG_BITS-1:0] valx;
  logic [DIG_BITS-1:0] oct_dig;
  logic [3:0]          cur_dig;
  logic [7:0]          emit_char;
  logic                out_busy;

  function automatic logic [6:0] eff_width(input logic [1:0] sz);
    logic [6:0] wcls;
    wcls = 7'd8 << sz;
    return (wcls > 7'(VALUE_BITS)) ? 7'(VALUE_BITS) : wcls;
  endfunction

  function automatic logic [VP-1:0] width_mask(input logic [1:0] sz);
    logic [VP-1:0] m;
    logic [6:0]    w;
    w = eff_width(sz);
    for (int i = 0; i < VP; i++) begin
      m[i] = (7'(i) < w);
    end
    return m;
  endfunction

  assign w_eff     = eff_width(size_r);
  assign mask_cur  = width_mask(size_r);
  assign in_val_vp = VP'(in_value[VALUE_BITS-1:0]);
  assign sign_idx  = SW'(w_eff - 7'd1);
  assign valx      = DIG_BITS'(val_r);
  assign cur_dig   = dig_r[cnt_r*4 +: 4];
  assign emit_char = digit_char(cur_dig, mode_r == MODE_HEXU);
  assign out_busy  = out_valid_r && !out_ready;

  always_comb begin
    for (int k = 0; k < DIG_SLOTS; k++) begin
      oct_dig[k*4 +: 4] = {1'b0, valx[k*3 +: 3]};
    end
  end

  // four shift-and-add-3 steps of binary to bcd per cycle
  always_comb begin
    logic [BCD_BITS-1:0] b;
    logic [VP-1:0]       v;
    b = bcd_r;
    v = val_r;
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < BCD_SLOTS; d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      b = {b[BCD_BITS-2:0], v[VP-1]};
      v = {v[VP-2:0], 1'b0};
    end
    bcd_nxt = b;
    val_nxt = v;
  end

  always_comb begin
    priority if (mode_r == MODE_PTR) begin
      cnt_top = CNT_W'((w_eff + 7'd3) >> 2) - 5'd1;
    end else if (mode_r == MODE_OCT) begin
      cnt_top = oct_top(size_r);
    end else if (mode_r == MODE_HEXL || mode_r == MODE_HEXU) begin
      cnt_top = hex_top(size_r);
    end else begin
      cnt_top = dec_top(size_r);
    end
  end

  always_comb begin
    priority if (mode_r == MODE_SDEC || mode_r == MODE_UDEC) begin
      dig_nxt = DIG_BITS'(bcd_r);
    end else if (mode_r == MODE_OCT) begin
      dig_nxt = oct_dig;
    end else begin
      dig_nxt = valx;
    end
  end

  always_comb begin
    flags.badmode  = mode_r > MODE_PTR;
    flags.ptr      = mode_r == MODE_PTR;
    flags.pow2     = mode_r == MODE_OCT || mode_r == MODE_HEXL || mode_r == MODE_HEXU;
    flags.neg      = (mode_r == MODE_SDEC) && val_r[sign_idx];
    flags.dab_more = dab_cnt_r != DCW'(NIB - 1);
    flags.leadz    = (cur_dig == 4'd0) && (cnt_r != '0);
    flags.cnt_nz   = cnt_r != '0;
    flags.out_busy = out_busy;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= in_mode;
      size_r    <= in_size_code;
      val_r     <= in_val_vp & width_mask(in_size_code);
      bcd_r     <= '0;
      dab_cnt_r <= '0;
    end else if (go) begin
      unique case (ctrl.op)
        OP_NEG: begin
          val_r <= (~val_r + 1'b1) & mask_cur;
        end
        OP_DAB: begin
          val_r     <= val_nxt;
          bcd_r     <= bcd_nxt;
          dab_cnt_r <= dab_cnt_r + 1'b1;
        end
        OP_DIGLD: begin
          dig_r <= dig_nxt;
          cnt_r <= cnt_top;
        end
        OP_SKIPZ: begin
          if (flags.leadz) begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        OP_DEC: begin
          cnt_r <= cnt_r - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && ctrl.emit != EM_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctrl.emit != EM_NONE) begin
      unique case (ctrl.emit)
        EM_MINUS: out_char_r <= CH_MINUS;
        EM_ZERO:  out_char_r <= CH_ZERO;
        EM_X:     out_char_r <= CH_X;
        default:  out_char_r <= emit_char;
      endcase
      out_last_r <= (ctrl.emit == EM_DIGIT) && (cnt_r == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule

// ----- hdl/integer_to_text_formatter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_text_formatter
// Formats one integer request as ASCII text, one character per result.
// ----------------------------------------------------------------------------
// in_req carries mode, size_code and a 64-bit value; out_res returns one
// character per transfer, the final one with last set. Modes six and seven
// are taken and produce no characters.
// One request is worked at a time; in_req.ready is high only while waiting.
// Steps per request:
//   hex, octal: digit load, leading-zero skip, digits (width class, 2..22 slots)
//   pointer:    '0', then 'x' with digit load, then ceil(width/4) digits
//   decimal:    '-' if negative, bcd conversion of the whole operand (four bits a
//               cycle), digit load, leading-zero skip, digits (3..20 slots)
// Leading zeros are dropped slot by slot before the first digit, except for pointers.
// The character register lets the sequencer run one step ahead of a stalled
// receiver; any further emitting step waits until the character is taken.
// Reset returns the sequencer to the wait step and drops out_res.valid.
// ----------------------------------------------------------------------------
module integer_to_text_formatter #(
  parameter int VALUE_BITS = 64
) (
  input logic       clk,
  input logic       rst_n,
  itf_in_if.sink    in_req,
  itf_out_if.source out_res
);
  import itf_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;
  logic   go;
  logic   in_ready;
  logic   accept;

  assign in_req.ready = in_ready;
  assign accept       = in_req.valid && in_ready;

  itf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .flags    (flags),
    .ctrl     (ctrl),
    .go       (go),
    .in_ready (in_ready)
  );

  itf_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .go            (go),
    .accept        (accept),
    .in_mode       (in_req.mode),
    .in_size_code  (in_req.size_code),
    .in_value      (in_req.value),
    .out_ready     (out_res.ready),
    .flags         (flags),
    .out_valid     (out_res.valid),
    .out_char_code (out_res.char_code),
    .out_last      (out_res.last)
  );

endmodule

// ----- dv/integer_to_text_formatter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_text_formatter_test
// Self-checking bench for the integer to ASCII text formatter.
// ----------------------------------------------------------------------------
// Number requests are fed through the valid/ready request channel from a
// queue of pending requests. Each accepted request is turned into its
// expected character string by a local formatter. Every character taken from
// the result channel is compared against the oldest expected character. Both
// channels idle at random, with one long calm stretch in the middle of the run.
// ----------------------------------------------------------------------------
module integer_to_text_formatter_test;
  import itf_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 80;
  localparam int RANDOM_ITEMS  = 450;
  localparam int CALM_FROM     = 3000;
  localparam int CALM_TO       = 5500;
  localparam int SHOWN_ERRORS  = 10;

  // modes with no text
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  localparam logic [1:0] SZ_8  = 2'd0;
  localparam logic [1:0] SZ_16 = 2'd1;
  localparam logic [1:0] SZ_32 = 2'd2;
  localparam logic [1:0] SZ_64 = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  size_code;
    logic [63:0] value;
  } number_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } text_char_t;

  logic clk;
  logic rst_n;

  itf_in_if  in_req ();
  itf_out_if out_res ();

  integer_to_text_formatter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req.sink),
    .out_res (out_res.source)
  );

  number_t    pending_numbers[$];
  text_char_t expected_text[$];

  int cycle_count   = 0;
  int numbers_taken = 0;
  int spare_taken   = 0;
  int chars_checked = 0;
  int mismatches    = 0;
  logic calm;

  assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.mode = MODE_SDEC;
    in_req.size_code = SZ_8;
    in_req.value = '0;
    out_res.ready = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic logic [7:0] glyph(input logic [3:0] d, input logic upper);
    if (d < 4'd10) begin
      return CH_ZERO + {4'd0, d};
    end
    return (upper ? CH_UA : CH_LA) + {4'd0, d} - 8'd10;
  endfunction

  // expected characters of one accepted request
  function automatic void predict_text(input number_t req);
    int         width;
    int         shift;
    int         digits;
    logic [63:0] mask;
    logic [63:0] v;
    logic [7:0]  txt[$];
    logic [7:0]  digs[$];
    text_char_t  c;
    width = 8 << req.size_code;
    mask = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
    v = req.value & mask;
    case (req.mode)
      MODE_SDEC, MODE_UDEC: begin
        if (req.mode == MODE_SDEC && v[width-1]) begin
          txt.push_back(CH_MINUS);
          v = ~(v | ~mask) + 64'd1;
        end
        do begin
          digs.push_front(CH_ZERO + 8'(v % 64'd10));
          v = v / 64'd10;
        end while (v != 0);
      end
      MODE_OCT, MODE_HEXL, MODE_HEXU: begin
        shift = (req.mode == MODE_OCT) ? 3 : 4;
        do begin
          if (shift == 3) begin
            digs.push_front(CH_ZERO + {5'd0, v[2:0]});
          end else begin
            digs.push_front(glyph(v[3:0], req.mode == MODE_HEXU));
          end
          v = v >> shift;
        end while (v != 0);
      end
      MODE_PTR: begin
        txt.push_back(CH_ZERO);
        txt.push_back(CH_X);
        digits = (width + 3) / 4;
        for (int i = digits - 1; i >= 0; i--) begin
          digs.push_back(glyph(4'((v >> (4 * i)) & 64'hf), 1'b0));
        end
      end
      default: ;
    endcase
    foreach (digs[i]) txt.push_back(digs[i]);
    foreach (txt[i]) begin
      c.char_code = txt[i];
      c.last = (i == txt.size() - 1);
      expected_text.push_back(c);
    end
  endfunction

  function automatic void queue_number(input logic [2:0] mode, input logic [1:0] sz,
                                       input logic [63:0] value);
    number_t n;
    n.mode = mode;
    n.size_code = sz;
    n.value = value;
    pending_numbers.push_back(n);
  endfunction

  // random request, weighted towards edge values of the chosen width
  function automatic number_t random_number();
    number_t     n;
    logic [63:0] mask;
    logic [63:0] junk;
    int          width;
    n.mode = ($urandom_range(99) < 5) ? (MODE_SPARE6 + 3'($urandom_range(1)))
                                       : 3'($urandom_range(5));
    n.size_code = 2'($urandom_range(3));
    width = 8 << n.size_code;
    mask = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
    junk = {$urandom, $urandom};
    case ($urandom_range(9))
      0: n.value = '0;
      1: n.value = mask;
      2: n.value = 64'd1 << (width - 1);
      3: n.value = 64'($urandom_range(20));
      4: n.value = mask >> 1;
      5: n.value = (64'd1 << (width - 1)) | 64'd1;
      default: n.value = {$urandom, $urandom};
    endcase
    // garbage above the operand width must be ignored
    if ($urandom_range(1) == 1) begin
      n.value = (n.value & mask) | (junk & ~mask);
    end
    return n;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        predict_text({in_req.mode, in_req.size_code, in_req.value});
        if (in_req.mode > MODE_PTR) begin
          spare_taken++;
        end else begin
          numbers_taken++;
        end
      end
      if (!in_req.valid || in_req.ready) begin
        if (pending_numbers.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          number_t nxt;
          nxt = pending_numbers.pop_front();
          in_req.valid <= 1'b1;
          in_req.mode <= nxt.mode;
          in_req.size_code <= nxt.size_code;
          in_req.value <= nxt.value;
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  // character checker
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      chars_checked++;
      if (expected_text.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
          $display("[%0t] character %h last %b with no request outstanding",
                   $realtime, out_res.char_code, out_res.last);
        end
      end else begin
        want = expected_text.pop_front();
        if (out_res.char_code !== want.char_code || out_res.last !== want.last) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS) begin
            $display("[%0t] character mismatch: expected %h last %b, got %h last %b",
                     $realtime, want.char_code, want.last, out_res.char_code,
                     out_res.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still expected",
               cycle_count, expected_text.size());
      $display("integer_to_text_formatter verification failed");
      $finish;
    end
  end

  initial begin
    int taken;
    number_t n;

    // edge cases of every format
    queue_number(MODE_SDEC, SZ_8,  64'h80);
    queue_number(MODE_SDEC, SZ_64, 64'h8000_0000_0000_0000);
    queue_number(MODE_SDEC, SZ_64, '1);
    queue_number(MODE_SDEC, SZ_8,  64'hffff_ffff_ffff_ff7f);
    queue_number(MODE_SDEC, SZ_32, 64'hffff_ffff_0000_0000);
    queue_number(MODE_SDEC, SZ_16, 64'h0000_0000_0000_ffff);
    queue_number(MODE_UDEC, SZ_64, '1);
    queue_number(MODE_UDEC, SZ_8,  64'h0);
    queue_number(MODE_UDEC, SZ_32, 64'h0000_0000_ffff_ffff);
    queue_number(MODE_OCT,  SZ_64, '1);
    queue_number(MODE_OCT,  SZ_8,  64'h0);
    queue_number(MODE_OCT,  SZ_16, 64'hffff_ffff_ffff_01ff);
    queue_number(MODE_HEXL, SZ_64, 64'hdead_beef_0bad_f00d);
    queue_number(MODE_HEXL, SZ_8,  64'h0);
    queue_number(MODE_HEXU, SZ_32, 64'h5555_5555_abcd_ef12);
    queue_number(MODE_HEXU, SZ_16, 64'h0);
    queue_number(MODE_PTR,  SZ_8,  64'h05);
    queue_number(MODE_PTR,  SZ_16, '1);
    queue_number(MODE_PTR,  SZ_32, 64'h1234_abcd);
    queue_number(MODE_PTR,  SZ_64, 64'h0);
    queue_number(MODE_SPARE6, SZ_32, 64'h1234);
    queue_number(MODE_SPARE7, SZ_64, '1);
    queue_number(MODE_UDEC, SZ_64, 64'h0000_0000_0000_0001);

    taken = 0;
    while (taken < RANDOM_ITEMS) begin
      n = random_number();
      pending_numbers.push_back(n);
      if (n.mode <= MODE_PTR) taken++;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_numbers.size() != 0 || in_req.valid || expected_text.size() != 0) begin
      @(posedge clk);
    end
    // spare modes may still be in flight with nothing to show
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests: %0d formatted over all six formats and four widths, %0d spare-mode",
             numbers_taken, spare_taken);
    $display("characters compared: %0d, mismatches: %0d", chars_checked, mismatches);
    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("integer_to_text_formatter verification clean");
    end else begin
      $display("integer_to_text_formatter verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/itf_pkg.sv
hdl/itf_if.sv
hdl/itf_seq.sv
hdl/itf_dp.sv
hdl/integer_to_text_formatter.sv
dv/integer_to_text_formatter_test.sv
